[src/tfpm_pkg.sv]
// Shared types and constants for the touch frame to pointer motion block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package tfpm_pkg;

  localparam int NUM_SLOTS   = 8;
  localparam int SLOT_IW     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int PIXEL_SHIFT = 6;   // residual units per pixel: 64
  localparam int STEP_SHIFT  = 10;  // residual units per wheel step: 1024

  localparam logic [2:0] CNT_ONE = 3'd1;
  localparam logic [2:0] CNT_TWO = 3'd2;

  typedef struct packed {
    logic [3:0]  frame_slot;
    logic [7:0]  frame_report_id;
    logic [2:0]  frame_button_mask;
    logic [2:0]  frame_button_levels;
    logic        touch_present;
    logic [2:0]  finger_count;
    logic [15:0] first_x;
    logic [15:0] first_y;
    logic [31:0] first_finger_id;
    logic [15:0] second_x;
    logic [15:0] second_y;
    logic [31:0] second_id;
  } frame_t;

  typedef struct packed {
    logic signed [11:0] move_x;
    logic signed [11:0] move_y;
    logic signed [7:0]  wheel_steps;
  } motion_t;

endpackage

`default_nettype wire

[src/touch_frame_to_pointer_motion.sv]
// Top level: input register, button and gesture units, result register.
// Depends on tfpm_pkg, tfpm_buttons and tfpm_gesture.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake               Payload
// in_*      input      in_valid / in_ready     one decoded touchpad frame
// out_*     output     out_valid / out_ready   move_x, move_y, wheel_steps, button_state
//
// One transaction in gives exactly one transaction out. A frame is captured in
// the input register, evaluated combinationally against the gesture and button
// state, and written to the result register. One frame per cycle is sustained
// while the output does not stall. The state update happens on the same edge as
// the result write, so the next frame always sees it. Reset clears all state and
// both valid flags. A stalled output holds its result; the input register still
// takes a frame and drains it as soon as the result is taken.

module touch_frame_to_pointer_motion import tfpm_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [3:0]         in_frame_slot,
  input  wire logic [7:0]         in_frame_report_id,
  input  wire logic [2:0]         in_frame_button_mask,
  input  wire logic [2:0]         in_frame_button_levels,
  input  wire logic               in_touch_present,
  input  wire logic [2:0]         in_finger_count,
  input  wire logic [15:0]        in_first_x,
  input  wire logic [15:0]        in_first_y,
  input  wire logic [31:0]        in_first_finger_id,
  input  wire logic [15:0]        in_second_x,
  input  wire logic [15:0]        in_second_y,
  input  wire logic [31:0]        in_second_id,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [11:0]      out_move_x,
  output logic signed [11:0]      out_move_y,
  output logic signed [7:0]       out_wheel_steps,
  output logic [2:0]              out_button_state
);

  frame_t     frame_r;
  logic       frame_valid_r;
  logic       out_valid_r;
  motion_t    motion_r;
  logic [2:0] button_r;

  logic       advance;
  logic       slot_ok;
  logic       upd;
  motion_t    motion;
  logic [2:0] button;

  // Advance the held frame whenever the result register is free or draining.
  assign advance  = frame_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !frame_valid_r || advance;
  assign slot_ok  = ({1'b0, frame_r.frame_slot} < 5'(NUM_SLOTS));
  assign upd      = advance && slot_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_valid_r <= 1'b0;
    end else if (in_ready) begin
      frame_valid_r <= in_valid;
    end
  end

  // Payload capture; no reset needed.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      frame_r.frame_slot          <= in_frame_slot;
      frame_r.frame_report_id     <= in_frame_report_id;
      frame_r.frame_button_mask   <= in_frame_button_mask;
      frame_r.frame_button_levels <= in_frame_button_levels;
      frame_r.touch_present       <= in_touch_present;
      frame_r.finger_count        <= in_finger_count;
      frame_r.first_x             <= in_first_x;
      frame_r.first_y             <= in_first_y;
      frame_r.first_finger_id     <= in_first_finger_id;
      frame_r.second_x            <= in_second_x;
      frame_r.second_y            <= in_second_y;
      frame_r.second_id           <= in_second_id;
    end
  end

  tfpm_buttons u_buttons (
    .clk            (clk),
    .rst_n          (rst_n),
    .upd_i          (upd),
    .slot_i         (frame_r.frame_slot),
    .mask_i         (frame_r.frame_button_mask),
    .levels_i       (frame_r.frame_button_levels),
    .button_state_o (button)
  );

  tfpm_gesture u_gesture (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd_i    (upd),
    .frame_i  (frame_r),
    .motion_o (motion)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Drop everything to zero for a slot outside the table.
  always_ff @(posedge clk) begin
    if (advance) begin
      motion_r <= slot_ok ? motion : '0;
      button_r <= slot_ok ? button : 3'b000;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_move_x       = motion_r.move_x;
  assign out_move_y       = motion_r.move_y;
  assign out_wheel_steps  = motion_r.wheel_steps;
  assign out_button_state = button_r;

endmodule

`default_nettype wire

[src/tfpm_buttons.sv]
// Per-slot button level store and OR reduction over all slots.
// Depends on tfpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tfpm_buttons import tfpm_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             upd_i,
  input  wire logic [3:0]       slot_i,
  input  wire logic [2:0]       mask_i,
  input  wire logic [2:0]       levels_i,
  output logic      [2:0]       button_state_o
);

  logic [2:0] levels_r   [NUM_SLOTS];
  logic [2:0] levels_nxt [NUM_SLOTS];

  always_comb begin
    button_state_o = 3'b000;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      levels_nxt[i] = levels_r[i];
      if (upd_i && (mask_i != 3'b000) && (slot_i[SLOT_IW-1:0] == SLOT_IW'(i))) begin
        levels_nxt[i] = levels_i;
      end
      button_state_o = button_state_o | levels_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (!rst_n) begin
        levels_r[i] <= 3'b000;
      end else begin
        levels_r[i] <= levels_nxt[i];
      end
    end
  end

endmodule

`default_nettype wire

[src/tfpm_gesture.sv]
// Anchor formation, gesture continuation check and motion residuals.
// Depends on tfpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tfpm_gesture import tfpm_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    upd_i,
  input  wire frame_t  frame_i,
  output motion_t      motion_o
);

  logic [1:0]         count_r;
  logic [31:0]        low_id_r;
  logic [31:0]        high_id_r;
  logic [15:0]        anchor_x_r;
  logic [15:0]        anchor_y_r;
  logic [7:0]         last_rid_r;
  logic signed [6:0]  rest_x_r,  rest_x_nxt;
  logic signed [6:0]  rest_y_r,  rest_y_nxt;
  logic signed [10:0] rest_w_r,  rest_w_nxt;

  logic [1:0]         n;
  logic [15:0]        ax, ay;
  logic [31:0]        lo, hi;
  logic [16:0]        sum_x, sum_y;
  logic               cont;
  logic signed [17:0] ddx, ddy, sx, sy, sw, bx, by, bw;
  logic signed [17:0] rx, ry, rw;
  logic signed [11:0] qx, qy;
  logic signed [7:0]  qw;

  always_comb begin
    sum_x = {1'b0, frame_i.first_x} + {1'b0, frame_i.second_x};
    sum_y = {1'b0, frame_i.first_y} + {1'b0, frame_i.second_y};
    n  = 2'd0;
    ax = 16'd0;
    ay = 16'd0;
    lo = 32'd0;
    hi = 32'd0;
    if (frame_i.finger_count == CNT_ONE) begin
      n  = 2'd1;
      ax = frame_i.first_x;
      ay = frame_i.first_y;
      lo = frame_i.first_finger_id;
    end else if (frame_i.finger_count == CNT_TWO) begin
      n  = 2'd2;
      ax = sum_x[16:1];
      ay = sum_y[16:1];
      if (frame_i.first_finger_id < frame_i.second_id) begin
        lo = frame_i.first_finger_id;
        hi = frame_i.second_id;
      end else begin
        lo = frame_i.second_id;
        hi = frame_i.first_finger_id;
      end
    end

    cont = (n != 2'd0) && (n == count_r) && (frame_i.frame_report_id == last_rid_r) &&
           (lo == low_id_r) && (hi == high_id_r);

    ddx = $signed({2'b00, ax}) - $signed({2'b00, anchor_x_r});
    ddy = $signed({2'b00, ay}) - $signed({2'b00, anchor_y_r});
    sx  = ddx + 18'(rest_x_r);
    sy  = ddy + 18'(rest_y_r);
    sw  = ddy + 18'(rest_w_r);

    // Bias negative sums so the arithmetic shift truncates toward zero.
    bx = sx + (sx[17] ? 18'((1 << PIXEL_SHIFT) - 1) : 18'sd0);
    by = sy + (sy[17] ? 18'((1 << PIXEL_SHIFT) - 1) : 18'sd0);
    bw = sw + (sw[17] ? 18'((1 << STEP_SHIFT) - 1) : 18'sd0);
    qx = bx[17:PIXEL_SHIFT];
    qy = by[17:PIXEL_SHIFT];
    qw = bw[17:STEP_SHIFT];
    rx = sx - {qx, {PIXEL_SHIFT{1'b0}}};
    ry = sy - {qy, {PIXEL_SHIFT{1'b0}}};
    rw = sw - {qw, {STEP_SHIFT{1'b0}}};

    motion_o   = '0;
    rest_x_nxt = rest_x_r;
    rest_y_nxt = rest_y_r;
    rest_w_nxt = rest_w_r;
    if (frame_i.touch_present) begin
      if (cont && (n == 2'd1)) begin
        motion_o.move_x = qx;
        motion_o.move_y = qy;
        rest_x_nxt      = rx[6:0];
        rest_y_nxt      = ry[6:0];
      end else if (cont) begin
        motion_o.wheel_steps = qw;
        rest_w_nxt           = rw[10:0];
      end else begin
        rest_x_nxt = '0;
        rest_y_nxt = '0;
        rest_w_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= 2'd0;
      low_id_r   <= 32'd0;
      high_id_r  <= 32'd0;
      anchor_x_r <= 16'd0;
      anchor_y_r <= 16'd0;
      last_rid_r <= 8'd0;
      rest_x_r   <= '0;
      rest_y_r   <= '0;
      rest_w_r   <= '0;
    end else if (upd_i && frame_i.touch_present) begin
      count_r    <= n;
      low_id_r   <= lo;
      high_id_r  <= hi;
      anchor_x_r <= ax;
      anchor_y_r <= ay;
      last_rid_r <= frame_i.frame_report_id;
      rest_x_r   <= rest_x_nxt;
      rest_y_r   <= rest_y_nxt;
      rest_w_r   <= rest_w_nxt;
    end
  end

endmodule

`default_nettype wire
